>>> rtl/firewall_range_rule_table_assert.svh
// Assertion macros for the firewall range rule table checker.
// Used by fwrt_checker.sv; needs nothing else.
`ifndef FIREWALL_RANGE_RULE_TABLE_ASSERT_SVH
`define FIREWALL_RANGE_RULE_TABLE_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define FWRT_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define FWRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fwrt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes of the firewall range rule table.
// Stands alone; used by the top level, the rule RAM user and the checker.
package fwrt_pkg;

    localparam int RULE_SLOTS = 16;
    localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

    // port payload layout
    localparam int MSLOT_W    = 4;
    localparam int HELD_W     = 5;
    localparam int S_TDATA_W  = 144;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 3;

    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(RULE_SLOTS);
    localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(RULE_SLOTS);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_INVALID   = 3'd1,
        ST_ACCEPTED  = 3'd2,
        ST_REJECTED  = 3'd3,
        ST_DELETED   = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_FLUSHED   = 3'd6,
        ST_FULL      = 3'd7
    } status_t;

    // ip_low sits in the lowest bits, as on the request bus
    typedef struct packed {
        logic [15:0] port_high;
        logic [15:0] port_low;
        logic [31:0] ip_high;
        logic [31:0] ip_low;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    function automatic logic [CNT_W-1:0] slot_to_cnt(input logic [SLOT_W-1:0] s);
        return CNT_W'(s);
    endfunction

    function automatic logic [MSLOT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] s);
        return MSLOT_W'(s);
    endfunction

    function automatic logic [HELD_W-1:0] cnt_to_out(input logic [CNT_W-1:0] c);
        return HELD_W'(c);
    endfunction

endpackage

>>> rtl/firewall_range_rule_table.sv
`timescale 1ns / 1ps
// Top level of the firewall range rule table: command sequencer and result register.
// Depends on fwrt_pkg and fwrt_ram.
//
// One request in, one result out. Rules live in a single RAM read one slot per
// cycle, so its one read port sets the timing. Add, flush and invalid requests go
// straight to the result; check scans the held rules until one covers the query
// or the rules run out, and delete scans to the match, then shifts each later
// rule down one slot. A new request is taken as soon as the sequencer is idle,
// even while the last result still waits on m_tready.
module firewall_range_rule_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // range_ip_low, range_ip_high, range_port_low, range_port_high, query_ip, query_port
    input  logic [fwrt_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [fwrt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // match_slot, rules_held, zero pad
    output logic [fwrt_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic [fwrt_pkg::M_TUSER_W-1:0] m_tuser
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } fsm_state_t;

    fsm_state_t state_reg, state_next;

    logic [fwrt_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [fwrt_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        pend_reg, pend_next;
    logic [fwrt_pkg::SLOT_W-1:0] pend_idx_reg, pend_idx_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    fwrt_pkg::cmd_t              cmd_reg, cmd_next;
    fwrt_pkg::rule_t             rule_reg, rule_next;
    logic [31:0]                 qip_reg, qip_next;
    logic [15:0]                 qport_reg, qport_next;
    fwrt_pkg::status_t           res_status_reg, res_status_next;
    logic [fwrt_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    fwrt_pkg::status_t           out_status_reg, out_status_next;
    logic [fwrt_pkg::MSLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [fwrt_pkg::HELD_W-1:0] out_held_reg, out_held_next;

    logic                        accept;
    fwrt_pkg::cmd_t              in_cmd;
    fwrt_pkg::rule_t             in_rule;
    logic                        in_valid;
    logic                        issue;
    logic                        hit_cover;
    logic                        hit_same;
    logic [fwrt_pkg::CNT_W-1:0]  idx_m1;

    logic                        ram_we;
    logic [fwrt_pkg::SLOT_W-1:0] ram_waddr;
    fwrt_pkg::rule_t             ram_wdata;
    fwrt_pkg::rule_t             ram_rdata;

    fwrt_ram #(
        .WIDTH (fwrt_pkg::RULE_W),
        .DEPTH (fwrt_pkg::RULE_SLOTS)
    ) u_rules (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[fwrt_pkg::SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_cmd   = fwrt_pkg::cmd_t'(s_tuser);
    assign in_rule  = fwrt_pkg::rule_t'(s_tdata[fwrt_pkg::RULE_W-1:0]);
    assign in_valid = (in_rule.ip_low <= in_rule.ip_high) &&
                      (in_rule.port_low <= in_rule.port_high);

    assign issue     = (idx_reg < count_reg);
    assign idx_m1    = idx_reg - fwrt_pkg::CNT_ONE;
    assign hit_cover = (qip_reg >= ram_rdata.ip_low) && (qip_reg <= ram_rdata.ip_high) &&
                       (qport_reg >= ram_rdata.port_low) && (qport_reg <= ram_rdata.port_high);
    assign hit_same  = (ram_rdata == rule_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(fwrt_pkg::M_TDATA_W - fwrt_pkg::HELD_W - fwrt_pkg::MSLOT_W){1'b0}},
                       out_held_reg, out_slot_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        m_tvalid_next   = m_tvalid_reg;
        cmd_next        = cmd_reg;
        rule_next       = rule_reg;
        qip_next        = qip_reg;
        qport_next      = qport_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_held_next   = out_held_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[fwrt_pkg::SLOT_W-1:0];
        ram_wdata       = in_rule;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = in_cmd;
                    rule_next     = in_rule;
                    qip_next      = s_tdata[127:96];
                    qport_next    = s_tdata[143:128];
                    res_slot_next = '0;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    state_next    = S_FINISH;
                    unique case (in_cmd)
                        fwrt_pkg::CMD_ADD:
                        begin
                            priority if (!in_valid)
                            begin
                                res_status_next = fwrt_pkg::ST_INVALID;
                            end
                            else if (count_reg == fwrt_pkg::CNT_FULL)
                            begin
                                res_status_next = fwrt_pkg::ST_FULL;
                            end
                            else
                            begin
                                // append at the current fill point
                                ram_we          = 1'b1;
                                count_next      = count_reg + fwrt_pkg::CNT_ONE;
                                res_status_next = fwrt_pkg::ST_ADDED;
                            end
                        end
                        fwrt_pkg::CMD_CHECK:
                        begin
                            res_status_next = fwrt_pkg::ST_REJECTED;
                            state_next      = S_SCAN;
                        end
                        fwrt_pkg::CMD_DELETE:
                        begin
                            if (!in_valid)
                            begin
                                res_status_next = fwrt_pkg::ST_INVALID;
                            end
                            else
                            begin
                                res_status_next = fwrt_pkg::ST_NOT_FOUND;
                                state_next      = S_SCAN;
                            end
                        end
                        fwrt_pkg::CMD_FLUSH:
                        begin
                            count_next      = '0;
                            res_status_next = fwrt_pkg::ST_FLUSHED;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // pend marks read data of slot pend_idx arriving this cycle
                if (pend_reg && ((cmd_reg == fwrt_pkg::CMD_CHECK) ? hit_cover : hit_same))
                begin
                    res_slot_next = pend_idx_reg;
                    pend_next     = 1'b0;
                    if (cmd_reg == fwrt_pkg::CMD_CHECK)
                    begin
                        res_status_next = fwrt_pkg::ST_ACCEPTED;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        res_status_next = fwrt_pkg::ST_DELETED;
                        idx_next        = fwrt_pkg::slot_to_cnt(pend_idx_reg) +
                                          fwrt_pkg::CNT_ONE;
                        state_next      = S_SHIFT;
                    end
                end
                else if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[fwrt_pkg::SLOT_W-1:0];
                    idx_next      = idx_reg + fwrt_pkg::CNT_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SHIFT:
            begin
                // write back the slot read last cycle one place lower
                ram_we    = pend_reg;
                ram_waddr = pend_idx_reg;
                ram_wdata = ram_rdata;
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_m1[fwrt_pkg::SLOT_W-1:0];
                    idx_next      = idx_reg + fwrt_pkg::CNT_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - fwrt_pkg::CNT_ONE;
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = fwrt_pkg::slot_to_out(res_slot_reg);
                    out_held_next   = fwrt_pkg::cnt_to_out(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        cmd_reg        <= cmd_next;
        rule_reg       <= rule_next;
        qip_reg        <= qip_next;
        qport_reg      <= qport_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_held_reg   <= out_held_next;
    end

endmodule

>>> rtl/fwrt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fwrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/fwrt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the firewall range rule table, bound to the top level.
// Depends on fwrt_pkg and firewall_range_rule_table_assert.svh.
`include "firewall_range_rule_table_assert.svh"

module fwrt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [fwrt_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [fwrt_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fwrt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [fwrt_pkg::M_TUSER_W-1:0] m_tuser
);

    logic [fwrt_pkg::MSLOT_W-1:0] slot;
    logic [fwrt_pkg::HELD_W-1:0]  held;
    logic                         is_accepted;
    logic                         is_deleted;
    logic                         is_flushed;
    logic                         req_seen;

    assign slot        = m_tdata[fwrt_pkg::MSLOT_W-1:0];
    assign held        = m_tdata[fwrt_pkg::MSLOT_W +: fwrt_pkg::HELD_W];
    assign is_accepted = (m_tuser == fwrt_pkg::ST_ACCEPTED);
    assign is_deleted  = (m_tuser == fwrt_pkg::ST_DELETED);
    assign is_flushed  = (m_tuser == fwrt_pkg::ST_FLUSHED);
    assign req_seen    = s_tvalid && s_tready && (s_tdata != '0 || s_tuser != '0 || 1'b1);

    `FWRT_ASSERT_IMM(a_held_bound, clk, rst_n, m_tvalid, held <= fwrt_pkg::HELD_MAX, "rule count above table size")
    `FWRT_ASSERT_IMM(a_flush_empty, clk, rst_n, m_tvalid && is_flushed, held == '0, "flush left rules")
    `FWRT_ASSERT_IMM(a_slot_zero, clk, rst_n, m_tvalid && !is_accepted && !is_deleted, slot == '0, "slot set without a match")
    `FWRT_ASSERT_IMM(a_accept_slot, clk, rst_n, m_tvalid && is_accepted, fwrt_pkg::HELD_W'(slot) < held, "match beyond held rules")
    `FWRT_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready && !req_seen, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind firewall_range_rule_table fwrt_checker u_fwrt_checker (.*);
